// File: src/aesgcm_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// aesgcm_pkg
// Shared types and constants of the AES-GCM stream engine: word formats,
// item kinds, register indexes and the controller to datapath command set.
// ----------------------------------------------------------------------------
package aesgcm_pkg;

  // item kinds
  localparam logic [2:0] KIND_KEY  = 3'd0;
  localparam logic [2:0] KIND_IV   = 3'd1;
  localparam logic [2:0] KIND_AAD  = 3'd2;
  localparam logic [2:0] KIND_TEXT = 3'd3;
  localparam logic [2:0] KIND_FIN  = 3'd4;

  // configuration register indexes
  localparam logic [1:0] CFG_DECRYPT = 2'd0;
  localparam logic [1:0] CFG_ROUNDS  = 2'd1;
  localparam logic [1:0] CFG_TAGLEN  = 2'd2;

  localparam logic [3:0] MIN_ROUNDS = 4'd10;

  // GHASH multiplier: four operand bits a cycle
  localparam int          GhStepBits = 4;
  localparam logic [4:0]  GH_LAST_STEP = 5'd31;

  typedef struct packed {
    logic [2:0]  kind;
    logic [63:0] word_hi;
    logic [63:0] word_lo;
    logic [3:0]  key_index;
    logic [4:0]  chunk_bytes;
    logic        last_chunk;
  } in_word_t;

  typedef struct packed {
    logic [63:0] out_hi;
    logic [63:0] out_lo;
    logic [4:0]  out_bytes;
    logic        is_tag;
    logic        tag_ok;
  } out_word_t;

  typedef enum logic [1:0] {
    AES_ZERO,
    AES_CTR,
    AES_J0
  } aes_src_e;

  typedef enum logic [1:0] {
    GH_IN,
    GH_IVLEN,
    GH_LENS,
    GH_TEXT
  } gh_src_e;

  typedef struct packed {
    logic       in_load;
    logic       ram_we;
    logic [3:0] ram_raddr;
    logic       aes_load;
    aes_src_e   aes_src;
    logic       aes_round;
    logic       aes_final;
    logic       h_set;
    logic       txt_load;
    logic       gh_start;
    gh_src_e    gh_src;
    logic       gh_step;
    logic       gh_last;
    logic       iv_start;
    logic       iv_add;
    logic       aad_add;
    logic       txt_add;
    logic       ctr_inc;
    logic       iv_fin;
    logic       j0_from_acc;
    logic       res_load;
    logic       res_tag;
  } cmd_t;

  typedef struct packed {
    logic iv_is12;
  } stat_t;

endpackage
`default_nettype wire

// File: src/aes_gcm_stream_engine_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// aes_gcm_stream_engine_unit
// AES-GCM encrypt/decrypt engine over 16-byte words, round keys loaded.
// ----------------------------------------------------------------------------
// Usage:
//   Load round keys as kind 0 words; loading the key of the last round also
//   derives the hash key H. Then send IV words, AAD words, text words and
//   one finish word per message.
//   Each input word is taken on in_valid_i & in_ready_o; ready is high only
//   while the sequencer is idle, so one word is in flight at a time.
//   Work per word: IV and AAD words take one GHASH block (the GHASH unit
//   folds four bits a cycle); a text word takes one AES round a cycle
//   from the key RAM, then one GHASH block; finish takes one GHASH block
//   of the lengths, then the AES pass over J0; a last IV word adds a
//   length block unless the IV is 12 bytes.
//   Results (text words and the tag or tag check) sit in an output
//   register; a stalled receiver holds it and the next word is still
//   taken, the sequencer waits only when a second result is ready.
//   Configuration writes are always accepted; write them while idle.
//   Reset clears the message state and the hash key and resets the config
//   registers; the round key RAM holds nothing valid until loaded.
// ----------------------------------------------------------------------------
module aes_gcm_stream_engine_unit import aesgcm_pkg::*; #(
  parameter int ROUND_KEY_SLOTS = 15
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  output logic            in_ready_o,
  input  wire in_word_t   in_word_i,
  output logic            out_valid_o,
  input  wire logic       out_ready_i,
  output out_word_t       out_word_o,
  input  wire logic       cfg_valid_i,
  output logic            cfg_ready_o,
  input  wire logic [1:0] cfg_index_i,
  input  wire logic [4:0] cfg_data_i
);

  cmd_t       cmd;
  stat_t      stat;
  logic       decrypt;
  logic [4:0] tag_bytes;

  // sequencer: phase, counters and commands
  aesgcm_ctrl #(
    .ROUND_KEY_SLOTS(ROUND_KEY_SLOTS)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_word_i   (in_word_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .stat_i      (stat),
    .cmd_o       (cmd),
    .decrypt_o   (decrypt),
    .tag_bytes_o (tag_bytes)
  );

  // AES round unit, GHASH multiplier and result register
  aesgcm_dp #(
    .ROUND_KEY_SLOTS(ROUND_KEY_SLOTS)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .in_word_i   (in_word_i),
    .decrypt_i   (decrypt),
    .tag_bytes_i (tag_bytes),
    .stat_o      (stat),
    .out_word_o  (out_word_o)
  );

  // text words never carry a tag check
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_word_o.is_tag |-> !out_word_o.tag_ok)
    else $error("text word with tag_ok set");

  // text words hold one to sixteen bytes
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_word_o.is_tag |->
      out_word_o.out_bytes != 5'd0 && out_word_o.out_bytes <= 5'd16)
    else $error("text word length out of range");

  // the result register is never loaded while a word still waits
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.res_load |-> !out_valid_o || out_ready_i)
    else $error("result overwritten");

  // no word is taken while the GHASH unit is busy
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.gh_step |-> !in_ready_o)
    else $error("input taken mid-hash");

endmodule
`default_nettype wire

// File: src/aesgcm_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// aesgcm_ram
// Generic single write, single read RAM with registered read data.
// ----------------------------------------------------------------------------
module aesgcm_ram #(
  parameter int WIDTH = 128,
  parameter int DEPTH = 15,
  localparam int AddrW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AddrW-1:0] waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic [AddrW-1:0] raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule
`default_nettype wire

// File: src/aesgcm_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// aesgcm_ctrl
// Sequencer: configuration registers, message phase, round and GHASH step
// counters, and the command word that drives the datapath.
// ----------------------------------------------------------------------------
module aesgcm_ctrl import aesgcm_pkg::*; #(
  parameter int ROUND_KEY_SLOTS = 15
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  output logic            in_ready_o,
  input  wire in_word_t   in_word_i,
  output logic            out_valid_o,
  input  wire logic       out_ready_i,
  input  wire logic       cfg_valid_i,
  output logic            cfg_ready_o,
  input  wire logic [1:0] cfg_index_i,
  input  wire logic [4:0] cfg_data_i,
  input  wire stat_t      stat_i,
  output cmd_t            cmd_o,
  output logic            decrypt_o,
  output logic [4:0]      tag_bytes_o
);

  typedef enum logic [2:0] {
    S_IDLE, S_AES_RD, S_AES_RUN, S_AES_END, S_GH_LD, S_GH_RUN, S_IV_FIN, S_EMIT
  } state_e;

  typedef enum logic [2:0] {
    PH_IDLE, PH_IV, PH_AAD, PH_TEXT, PH_DONE
  } phase_e;

  state_e     state_q, state_d;
  phase_e     phase_q, phase_d;
  logic [2:0] kind_q, kind_d;
  logic       last_q, last_d;
  logic       lenpass_q, lenpass_d;
  logic [3:0] rnd_q, rnd_d;
  logic [4:0] ghc_q, ghc_d;
  aes_src_e   aes_src_q, aes_src_d;
  gh_src_e    gh_src_q, gh_src_d;
  logic       out_valid_q, out_valid_d;
  logic       decrypt_q;
  logic [3:0] rounds_q;
  logic [4:0] tag_bytes_q;
  logic [3:0] eff_rounds;
  logic       accept;

  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;
  assign decrypt_o   = decrypt_q;
  assign tag_bytes_o = tag_bytes_q;
  assign accept      = in_valid_i & in_ready_o;

  always_comb begin
    if (rounds_q < MIN_ROUNDS) begin
      eff_rounds = MIN_ROUNDS;
    end else if (rounds_q > 4'(ROUND_KEY_SLOTS - 1)) begin
      eff_rounds = 4'(ROUND_KEY_SLOTS - 1);
    end else begin
      eff_rounds = rounds_q;
    end
  end

  always_comb begin
    state_d     = state_q;
    phase_d     = phase_q;
    kind_d      = kind_q;
    last_d      = last_q;
    lenpass_d   = lenpass_q;
    rnd_d       = rnd_q;
    ghc_d       = ghc_q;
    aes_src_d   = aes_src_q;
    gh_src_d    = gh_src_q;
    out_valid_d = out_valid_q & ~out_ready_i;
    cmd_o       = '0;
    cmd_o.aes_src = aes_src_q;
    cmd_o.gh_src  = gh_src_q;

    case (state_q)
      S_IDLE: begin
        if (accept) begin
          cmd_o.in_load = 1'b1;
          kind_d    = in_word_i.kind;
          last_d    = in_word_i.last_chunk;
          lenpass_d = 1'b0;
          gh_src_d  = GH_IN;
          case (in_word_i.kind)
            KIND_KEY: begin
              if (in_word_i.key_index < 4'(ROUND_KEY_SLOTS)) begin
                cmd_o.ram_we = 1'b1;
                if (in_word_i.key_index == eff_rounds) begin
                  aes_src_d = AES_ZERO;
                  state_d   = S_AES_RD;
                end
              end
            end
            KIND_IV: begin
              if (phase_q == PH_IDLE || phase_q == PH_IV) begin
                cmd_o.iv_start = (phase_q == PH_IDLE);
                cmd_o.iv_add   = 1'b1;
                phase_d = in_word_i.last_chunk ? PH_AAD : PH_IV;
                state_d = S_GH_LD;
              end
            end
            KIND_AAD: begin
              if (phase_q == PH_AAD) begin
                cmd_o.aad_add = 1'b1;
                if (in_word_i.last_chunk) begin
                  phase_d = PH_TEXT;
                end
                state_d = S_GH_LD;
              end
            end
            KIND_TEXT: begin
              if (phase_q == PH_AAD || phase_q == PH_TEXT) begin
                cmd_o.ctr_inc = 1'b1;
                cmd_o.txt_add = 1'b1;
                phase_d   = in_word_i.last_chunk ? PH_DONE : PH_TEXT;
                aes_src_d = AES_CTR;
                state_d   = S_AES_RD;
              end
            end
            KIND_FIN: begin
              if (phase_q inside {PH_AAD, PH_TEXT, PH_DONE}) begin
                phase_d  = PH_IDLE;
                gh_src_d = GH_LENS;
                state_d  = S_GH_LD;
              end
            end
            default: begin
              // drop unknown kinds
            end
          endcase
        end
      end

      S_AES_RD: begin
        cmd_o.ram_raddr = 4'd0;
        rnd_d   = 4'd0;
        state_d = S_AES_RUN;
      end

      S_AES_RUN: begin
        cmd_o.ram_raddr = (rnd_q == eff_rounds) ? 4'd0 : rnd_q + 4'd1;
        if (rnd_q == 4'd0) begin
          cmd_o.aes_load = 1'b1;
        end else begin
          cmd_o.aes_round = 1'b1;
          cmd_o.aes_final = (rnd_q == eff_rounds);
        end
        if (rnd_q == eff_rounds) begin
          state_d = S_AES_END;
        end else begin
          rnd_d = rnd_q + 4'd1;
        end
      end

      S_AES_END: begin
        case (kind_q)
          KIND_KEY: begin
            cmd_o.h_set = 1'b1;
            state_d = S_IDLE;
          end
          KIND_TEXT: begin
            cmd_o.txt_load = 1'b1;
            gh_src_d = GH_TEXT;
            state_d  = S_GH_LD;
          end
          default: begin
            state_d = S_EMIT;
          end
        endcase
      end

      S_GH_LD: begin
        cmd_o.gh_start = 1'b1;
        ghc_d   = 5'd0;
        state_d = S_GH_RUN;
      end

      S_GH_RUN: begin
        cmd_o.gh_step = 1'b1;
        cmd_o.gh_last = (ghc_q == GH_LAST_STEP);
        ghc_d = ghc_q + 5'd1;
        if (ghc_q == GH_LAST_STEP) begin
          case (kind_q)
            KIND_IV: begin
              if (!last_q) begin
                state_d = S_IDLE;
              end else if (lenpass_q) begin
                // length block folded in: mark the pass as done
                gh_src_d = GH_IN;
                state_d  = S_IV_FIN;
              end else begin
                lenpass_d = 1'b1;
                gh_src_d  = GH_IVLEN;
                state_d   = S_IV_FIN;
              end
            end
            KIND_TEXT: begin
              state_d = S_EMIT;
            end
            KIND_FIN: begin
              aes_src_d = AES_J0;
              state_d   = S_AES_RD;
            end
            default: begin
              state_d = S_IDLE;
            end
          endcase
        end
      end

      S_IV_FIN: begin
        // first visit after the data pass with a non-12-byte IV: hash length
        if (lenpass_q && (gh_src_q == GH_IVLEN) && !stat_i.iv_is12) begin
          state_d  = S_GH_LD;
          cmd_o.gh_src = GH_IVLEN;
        end else begin
          cmd_o.iv_fin      = 1'b1;
          cmd_o.j0_from_acc = !stat_i.iv_is12;
          state_d = S_IDLE;
        end
      end

      S_EMIT: begin
        if (!out_valid_q || out_ready_i) begin
          cmd_o.res_load = 1'b1;
          cmd_o.res_tag  = (kind_q == KIND_FIN);
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase

    if (state_q == S_GH_LD) begin
      cmd_o.gh_src = gh_src_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      phase_q     <= PH_IDLE;
      kind_q      <= KIND_KEY;
      last_q      <= 1'b0;
      lenpass_q   <= 1'b0;
      rnd_q       <= '0;
      ghc_q       <= '0;
      aes_src_q   <= AES_ZERO;
      gh_src_q    <= GH_IN;
      out_valid_q <= 1'b0;
      decrypt_q   <= 1'b0;
      rounds_q    <= MIN_ROUNDS;
      tag_bytes_q <= 5'd16;
    end else begin
      state_q     <= state_d;
      phase_q     <= phase_d;
      kind_q      <= kind_d;
      last_q      <= last_d;
      lenpass_q   <= lenpass_d;
      rnd_q       <= rnd_d;
      ghc_q       <= ghc_d;
      aes_src_q   <= aes_src_d;
      gh_src_q    <= gh_src_d;
      out_valid_q <= out_valid_d;
      if (cfg_valid_i) begin
        case (cfg_index_i)
          CFG_DECRYPT: decrypt_q   <= cfg_data_i[0];
          CFG_ROUNDS:  rounds_q    <= cfg_data_i[3:0];
          CFG_TAGLEN:  tag_bytes_q <= cfg_data_i;
          default: begin
          end
        endcase
      end
    end
  end

endmodule
`default_nettype wire

// File: src/aesgcm_dp.sv
`default_nettype none
// ----------------------------------------------------------------------------
// aesgcm_dp
// Datapath: round key RAM, one AES round a cycle, 4-bit-a-cycle GHASH
// multiplier, counter block, byte counts and the result register.
// ----------------------------------------------------------------------------
module aesgcm_dp import aesgcm_pkg::*; #(
  parameter int ROUND_KEY_SLOTS = 15
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire cmd_t       cmd_i,
  input  wire in_word_t   in_word_i,
  input  wire logic       decrypt_i,
  input  wire logic [4:0] tag_bytes_i,
  output stat_t           stat_o,
  output out_word_t       out_word_o
);

  localparam int AddrW = (ROUND_KEY_SLOTS > 1) ? $clog2(ROUND_KEY_SLOTS) : 1;

  localparam logic [7:0] SBOX [256] = '{
    8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
    8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
    8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
    8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
    8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
    8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
    8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
    8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
    8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
    8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
    8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
    8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
    8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
    8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
    8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
    8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
  };

  function automatic logic [7:0] xtime(input logic [7:0] b);
    return {b[6:0], 1'b0} ^ (b[7] ? 8'h1b : 8'h00);
  endfunction

  function automatic logic [127:0] aes_round(input logic [127:0] s, input logic [127:0] k,
                                             input logic fin);
    logic [7:0]   t [16];
    logic [7:0]   a0, a1, a2, a3, all;
    logic [127:0] r;
    for (int c = 0; c < 4; c++) begin
      for (int i = 0; i < 4; i++) begin
        t[c*4+i] = SBOX[s[127-8*((((c+i)%4)*4)+i) -: 8]];
      end
    end
    for (int c = 0; c < 4; c++) begin
      a0  = t[c*4];
      a1  = t[c*4+1];
      a2  = t[c*4+2];
      a3  = t[c*4+3];
      all = a0 ^ a1 ^ a2 ^ a3;
      if (fin) begin
        r[127-32*c -: 32] = {a0, a1, a2, a3};
      end else begin
        r[127-32*c -: 32] = {a0 ^ all ^ xtime(a0 ^ a1), a1 ^ all ^ xtime(a1 ^ a2),
                             a2 ^ all ^ xtime(a2 ^ a3), a3 ^ all ^ xtime(a3 ^ a0)};
      end
    end
    return r ^ k;
  endfunction

  function automatic logic [4:0] chunk_len(input logic [4:0] cb, input logic last);
    if (!last || cb > 5'd16) begin
      return 5'd16;
    end else if (cb == 5'd0) begin
      return 5'd1;
    end
    return cb;
  endfunction

  function automatic logic [127:0] lead_mask(input logic [4:0] n);
    return ~({128{1'b1}} >> {n, 3'b000});
  endfunction

  in_word_t     in_q;
  logic [127:0] state_q, h_q, j0_q, acc_q, txt_q;
  logic [127:0] gx_q, gv_q, gz_q;
  logic [31:0]  ctr_q;
  logic [63:0]  iv_cnt_q, aad_cnt_q, txt_cnt_q;
  out_word_t    res_q;
  logic [127:0] rkey;
  logic [127:0] in_blk, in_mask, aes_src, gh_op, gv_n, gz_n, j0_new, tag, tag_mask;
  logic [4:0]   n_live, n_q, tb;
  logic [63:0]  n_live64;

  aesgcm_ram #(
    .WIDTH(128),
    .DEPTH(ROUND_KEY_SLOTS)
  ) u_key_ram (
    .clk_i   (clk_i),
    .we_i    (cmd_i.ram_we),
    .waddr_i (in_word_i.key_index[AddrW-1:0]),
    .wdata_i ({in_word_i.word_hi, in_word_i.word_lo}),
    .raddr_i (cmd_i.ram_raddr[AddrW-1:0]),
    .rdata_o (rkey)
  );

  assign n_live   = chunk_len(in_word_i.chunk_bytes, in_word_i.last_chunk);
  assign n_live64 = {59'd0, n_live};
  assign n_q      = chunk_len(in_q.chunk_bytes, in_q.last_chunk);
  assign in_mask  = lead_mask(n_q);
  assign in_blk   = {in_q.word_hi, in_q.word_lo} & in_mask;
  assign stat_o.iv_is12 = (iv_cnt_q == 64'd12);

  always_comb begin
    case (cmd_i.aes_src)
      AES_CTR: aes_src = {j0_q[127:32], ctr_q};
      AES_J0:  aes_src = j0_q;
      default: aes_src = '0;
    endcase
  end

  always_comb begin
    case (cmd_i.gh_src)
      GH_IVLEN: gh_op = {64'd0, iv_cnt_q[60:0], 3'b000};
      GH_LENS:  gh_op = {aad_cnt_q[60:0], 3'b000, txt_cnt_q[60:0], 3'b000};
      GH_TEXT:  gh_op = decrypt_i ? in_blk : txt_q;
      default:  gh_op = in_blk;
    endcase
  end

  // four bits of the GF(2^128) product, most significant first
  always_comb begin
    gv_n = gv_q;
    gz_n = gz_q;
    for (int b = 0; b < GhStepBits; b++) begin
      if (gx_q[127-b]) begin
        gz_n = gz_n ^ gv_n;
      end
      gv_n = {gv_n[0] ? 8'he1 : 8'h00, 120'd0} ^ (gv_n >> 1);
    end
  end

  assign j0_new = cmd_i.j0_from_acc ? acc_q : {in_q.word_hi, in_q.word_lo[63:32], 32'd1};

  always_comb begin
    if (tag_bytes_i == 5'd0) begin
      tb = 5'd1;
    end else if (tag_bytes_i > 5'd16) begin
      tb = 5'd16;
    end else begin
      tb = tag_bytes_i;
    end
  end
  assign tag      = acc_q ^ state_q;
  assign tag_mask = lead_mask(tb);

  // payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.in_load) begin
      in_q <= in_word_i;
    end
    if (cmd_i.aes_load) begin
      state_q <= aes_src ^ rkey;
    end else if (cmd_i.aes_round) begin
      state_q <= aes_round(state_q, rkey, cmd_i.aes_final);
    end
    if (cmd_i.txt_load) begin
      txt_q <= ({in_q.word_hi, in_q.word_lo} ^ state_q) & in_mask;
    end
    if (cmd_i.gh_start) begin
      gx_q <= acc_q ^ gh_op;
      gv_q <= h_q;
      gz_q <= '0;
    end else if (cmd_i.gh_step) begin
      gx_q <= gx_q << GhStepBits;
      gv_q <= gv_n;
      gz_q <= gz_n;
    end
    if (cmd_i.res_load) begin
      if (!cmd_i.res_tag) begin
        res_q <= '{out_hi: txt_q[127:64], out_lo: txt_q[63:0], out_bytes: n_q,
                   is_tag: 1'b0, tag_ok: 1'b0};
      end else if (decrypt_i) begin
        res_q <= '{out_hi: 64'd0, out_lo: 64'd0, out_bytes: 5'd0, is_tag: 1'b1,
                   tag_ok: (((tag ^ {in_q.word_hi, in_q.word_lo}) & tag_mask) == '0)};
      end else begin
        res_q <= '{out_hi: tag[127:64] & tag_mask[127:64],
                   out_lo: tag[63:0] & tag_mask[63:0],
                   out_bytes: tb, is_tag: 1'b1, tag_ok: 1'b0};
      end
    end
  end

  // message state, cleared at reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      h_q       <= '0;
      j0_q      <= '0;
      acc_q     <= '0;
      ctr_q     <= '0;
      iv_cnt_q  <= '0;
      aad_cnt_q <= '0;
      txt_cnt_q <= '0;
    end else begin
      if (cmd_i.h_set) begin
        h_q <= state_q;
      end
      if (cmd_i.iv_start) begin
        acc_q <= '0;
      end else if (cmd_i.gh_step && cmd_i.gh_last) begin
        acc_q <= gz_n;
      end else if (cmd_i.iv_fin) begin
        acc_q <= '0;
      end
      if (cmd_i.iv_add) begin
        iv_cnt_q <= (cmd_i.iv_start ? 64'd0 : iv_cnt_q) + n_live64;
      end
      if (cmd_i.iv_fin) begin
        j0_q      <= j0_new;
        ctr_q     <= j0_new[31:0];
        aad_cnt_q <= '0;
        txt_cnt_q <= '0;
      end else begin
        if (cmd_i.ctr_inc) begin
          ctr_q <= ctr_q + 32'd1;
        end
        if (cmd_i.aad_add) begin
          aad_cnt_q <= aad_cnt_q + n_live64;
        end
        if (cmd_i.txt_add) begin
          txt_cnt_q <= txt_cnt_q + n_live64;
        end
      end
    end
  end

  assign out_word_o = res_q;

endmodule
`default_nettype wire
